FILE: design/gms_pkg.sv
// Shared types and codes for the gripper motion sequencer.
package gms_pkg;

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_AUTO_INIT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STATUS_GRACE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_TOLERANCE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STILL_EPSILON  = 3'd5;

    localparam logic [CFG_BITS-1:0] RST_INIT_TIMEOUT   = 16'd5000;
    localparam logic [CFG_BITS-1:0] RST_MOTION_TIMEOUT = 16'd10000;
    localparam logic [CFG_BITS-1:0] RST_STATUS_GRACE   = 16'd300;
    localparam logic [CFG_BITS-1:0] RST_POS_TOLERANCE  = 16'd10;
    localparam logic [CFG_BITS-1:0] RST_STILL_EPSILON  = 16'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] LBL_MOVING   = 2'd0;
    localparam logic [1:0] LBL_IN_PLACE = 2'd1;
    localparam logic [1:0] LBL_CLAMPING = 2'd2;
    localparam logic [1:0] LBL_DROPPING = 2'd3;

    localparam logic [1:0] WR_OK       = 2'd0;
    localparam logic [1:0] WR_REJECTED = 2'd1;

    localparam int TARGET_OUT_BITS = 16;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_INIT  = 2'd2,
        ACC_WRITE = 2'd3
    } access_t;

    typedef enum logic [3:0] {
        OC_NONE       = 4'd0,
        OC_REACHED    = 4'd1,
        OC_CLAMPED    = 4'd2,
        OC_NOTINIT    = 4'd3,
        OC_COMM       = 4'd4,
        OC_TIMEOUT    = 4'd5,
        OC_REJECTED   = 4'd6,
        OC_DROPPED    = 4'd7,
        OC_OBSTRUCTED = 4'd8
    } outcome_t;

    typedef struct packed {
        logic                auto_init_en;
        logic [CFG_BITS-1:0] init_timeout_ms;
        logic [CFG_BITS-1:0] motion_timeout_ms;
        logic [CFG_BITS-1:0] status_grace_ms;
        logic [CFG_BITS-1:0] position_tolerance;
        logic [CFG_BITS-1:0] still_epsilon;
    } cfg_t;

endpackage

FILE: design/gms_cfg.sv
// Configuration register file for the gripper motion sequencer.
module gms_cfg import gms_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_AUTO_INIT:      cfg_next.auto_init_en       = cfg_data[0];
                REG_INIT_TIMEOUT:   cfg_next.init_timeout_ms    = cfg_data;
                REG_MOTION_TIMEOUT: cfg_next.motion_timeout_ms  = cfg_data;
                REG_STATUS_GRACE:   cfg_next.status_grace_ms    = cfg_data;
                REG_POS_TOLERANCE:  cfg_next.position_tolerance = cfg_data;
                REG_STILL_EPSILON:  cfg_next.still_epsilon      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_init_en       <= 1'b1;
            cfg_reg.init_timeout_ms    <= RST_INIT_TIMEOUT;
            cfg_reg.motion_timeout_ms  <= RST_MOTION_TIMEOUT;
            cfg_reg.status_grace_ms    <= RST_STATUS_GRACE;
            cfg_reg.position_tolerance <= RST_POS_TOLERANCE;
            cfg_reg.still_epsilon      <= RST_STILL_EPSILON;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/gms_engine.sv
// Sequencer state, per-request step logic and result register.
module gms_engine import gms_pkg::*; #(
    parameter int TIME_BITS     = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  cfg_t                       cfg,
    input  logic                       item_command,
    input  logic [TIME_BITS-1:0]       item_now_ms,
    input  logic [POSITION_BITS-1:0]   item_target_position,
    input  logic                       item_read_ok,
    input  logic                       item_init_done,
    input  logic [1:0]                 item_clamp_label,
    input  logic [POSITION_BITS-1:0]   item_read_position,
    input  logic                       item_init_command_ok,
    input  logic [1:0]                 item_write_result,
    output logic                       res_accepted,
    output logic [2:0]                 res_seq_state,
    output logic [3:0]                 res_outcome,
    output logic [1:0]                 res_device_access,
    output logic [TARGET_OUT_BITS-1:0] res_target_out
);

    localparam int CW = (POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CHECK = 3'd1,
        PH_INIT  = 3'd2,
        PH_WRITE = 3'd3,
        PH_WAIT  = 3'd4,
        PH_OK    = 3'd5,
        PH_FAIL  = 3'd6
    } phase_t;

    function automatic logic [POSITION_BITS-1:0] absdiff(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    phase_t                   phase_reg, phase_next;
    outcome_t                 result_code_reg, result_code_next;
    logic [POSITION_BITS-1:0] goal_reg, goal_next;
    logic                     init_pending_reg, init_pending_next;
    logic                     motion_reg, motion_next;
    logic [TIME_BITS-1:0]     init_deadline_reg, init_deadline_next;
    logic [TIME_BITS-1:0]     move_deadline_reg, move_deadline_next;
    logic [TIME_BITS-1:0]     last_motion_reg, last_motion_next;
    logic [POSITION_BITS-1:0] start_pos_reg, start_pos_next;
    logic [POSITION_BITS-1:0] latest_pos_reg, latest_pos_next;
    logic [1:0]               first_label_reg, first_label_next;
    logic                     first_label_valid_reg, first_label_valid_next;
    logic                     label_changed_reg, label_changed_next;
    logic [POSITION_BITS-1:0] prev_pos_reg, prev_pos_next;
    logic                     prev_pos_valid_reg, prev_pos_valid_next;

    logic                       res_accepted_reg, res_accepted_next;
    access_t                    res_access_reg, res_access_next;
    logic [TARGET_OUT_BITS-1:0] res_target_reg, res_target_next;

    // wait-phase poll evaluation
    logic                 moved;
    logic                 near_goal;
    logic                 poll_motion;
    logic [TIME_BITS-1:0] poll_last_motion;
    logic [TIME_BITS-1:0] grace_gap;
    logic                 in_grace;
    logic                 poll_label_changed;
    logic [TIME_BITS-1:0] move_gap;
    logic [TIME_BITS-1:0] init_gap;
    logic                 move_hit;
    logic                 init_hit;
    logic                 idle_like;

    assign moved = CW'(absdiff(item_read_position, prev_pos_reg)) > CW'(cfg.still_epsilon);
    assign near_goal = CW'(absdiff(item_read_position, goal_reg))
                       <= CW'(cfg.position_tolerance);
    assign poll_motion = motion_reg | (prev_pos_valid_reg & moved)
                         | (item_clamp_label == LBL_MOVING);
    assign poll_last_motion = (!prev_pos_valid_reg || moved) ? item_now_ms : last_motion_reg;
    assign grace_gap = item_now_ms - poll_last_motion;
    assign in_grace = grace_gap < TIME_BITS'(cfg.status_grace_ms);
    assign poll_label_changed = label_changed_reg
                                | (first_label_valid_reg & (item_clamp_label != first_label_reg));
    assign move_gap = item_now_ms - move_deadline_reg;
    assign init_gap = item_now_ms - init_deadline_reg;
    assign move_hit = !move_gap[TIME_BITS-1];
    assign init_hit = !init_gap[TIME_BITS-1];
    assign idle_like = (phase_reg == PH_IDLE) || (phase_reg == PH_OK) || (phase_reg == PH_FAIL);

    always_comb begin
        phase_next             = phase_reg;
        result_code_next       = result_code_reg;
        goal_next              = goal_reg;
        init_pending_next      = init_pending_reg;
        motion_next            = motion_reg;
        init_deadline_next     = init_deadline_reg;
        move_deadline_next     = move_deadline_reg;
        last_motion_next       = last_motion_reg;
        start_pos_next         = start_pos_reg;
        latest_pos_next        = latest_pos_reg;
        first_label_next       = first_label_reg;
        first_label_valid_next = first_label_valid_reg;
        label_changed_next     = label_changed_reg;
        prev_pos_next          = prev_pos_reg;
        prev_pos_valid_next    = prev_pos_valid_reg;
        res_accepted_next      = 1'b1;
        res_access_next        = ACC_NONE;
        res_target_next        = '0;

        if (item_command == CMD_START) begin
            if (idle_like) begin
                goal_next              = item_target_position;
                result_code_next       = OC_NONE;
                init_pending_next      = 1'b0;
                motion_next            = 1'b0;
                init_deadline_next     = item_now_ms;
                move_deadline_next     = item_now_ms;
                last_motion_next       = item_now_ms;
                start_pos_next         = item_target_position;
                first_label_valid_next = 1'b0;
                label_changed_next     = 1'b0;
                prev_pos_valid_next    = 1'b0;
                phase_next             = PH_CHECK;
            end else begin
                res_accepted_next = 1'b0;
            end
        end else begin
            case (phase_reg)
                PH_CHECK: begin
                    res_access_next = ACC_READ;
                    if (!item_read_ok) begin
                        phase_next       = PH_FAIL;
                        result_code_next = OC_COMM;
                    end else begin
                        latest_pos_next = item_read_position;
                        if (item_init_done) begin
                            phase_next = PH_WRITE;
                        end else if (!cfg.auto_init_en) begin
                            phase_next       = PH_FAIL;
                            result_code_next = OC_NOTINIT;
                        end else begin
                            init_pending_next  = 1'b1;
                            init_deadline_next = item_now_ms
                                                 + TIME_BITS'(cfg.init_timeout_ms);
                            phase_next         = PH_INIT;
                        end
                    end
                end
                PH_INIT: begin
                    if (init_pending_reg) begin
                        res_access_next = ACC_INIT;
                        if (!item_init_command_ok) begin
                            phase_next       = PH_FAIL;
                            result_code_next = OC_COMM;
                        end else begin
                            init_pending_next = 1'b0;
                        end
                    end else begin
                        res_access_next = ACC_READ;
                        if (!item_read_ok) begin
                            phase_next       = PH_FAIL;
                            result_code_next = OC_COMM;
                        end else begin
                            latest_pos_next = item_read_position;
                            if (item_init_done) begin
                                phase_next = PH_WRITE;
                            end else if (init_hit) begin
                                phase_next       = PH_FAIL;
                                result_code_next = OC_TIMEOUT;
                            end
                        end
                    end
                end
                PH_WRITE: begin
                    res_access_next = ACC_WRITE;
                    res_target_next = TARGET_OUT_BITS'(goal_reg);
                    start_pos_next  = latest_pos_reg;
                    if (item_write_result == WR_REJECTED) begin
                        phase_next       = PH_FAIL;
                        result_code_next = OC_REJECTED;
                    end else if (item_write_result != WR_OK) begin
                        phase_next       = PH_FAIL;
                        result_code_next = OC_COMM;
                    end else begin
                        motion_next            = 1'b0;
                        first_label_valid_next = 1'b0;
                        label_changed_next     = 1'b0;
                        prev_pos_valid_next    = 1'b0;
                        last_motion_next       = item_now_ms;
                        move_deadline_next     = item_now_ms
                                                 + TIME_BITS'(cfg.motion_timeout_ms);
                        phase_next             = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    res_access_next = ACC_READ;
                    if (!item_read_ok) begin
                        phase_next       = PH_FAIL;
                        result_code_next = OC_COMM;
                    end else begin
                        latest_pos_next = item_read_position;
                        if (!first_label_valid_reg) begin
                            first_label_next       = item_clamp_label;
                            first_label_valid_next = 1'b1;
                        end
                        label_changed_next  = poll_label_changed;
                        motion_next         = poll_motion;
                        last_motion_next    = poll_last_motion;
                        prev_pos_next       = item_read_position;
                        prev_pos_valid_next = 1'b1;
                        if (!poll_motion && near_goal) begin
                            phase_next       = PH_OK;
                            result_code_next = OC_REACHED;
                        end else if (in_grace) begin
                            if (move_hit) begin
                                phase_next       = PH_FAIL;
                                result_code_next = OC_TIMEOUT;
                            end
                        end else if (poll_label_changed
                                     && item_clamp_label == LBL_DROPPING) begin
                            phase_next       = PH_FAIL;
                            result_code_next = OC_DROPPED;
                        end else if (poll_label_changed
                                     && item_clamp_label == LBL_CLAMPING) begin
                            if (goal_reg > start_pos_reg && item_read_position < goal_reg) begin
                                phase_next       = PH_OK;
                                result_code_next = OC_CLAMPED;
                            end else begin
                                phase_next       = PH_FAIL;
                                result_code_next = OC_OBSTRUCTED;
                            end
                        end else if (near_goal && (!poll_label_changed
                                     || item_clamp_label == LBL_IN_PLACE)) begin
                            phase_next       = PH_OK;
                            result_code_next = OC_REACHED;
                        end else if (move_hit) begin
                            phase_next       = PH_FAIL;
                            result_code_next = OC_TIMEOUT;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_IDLE;
            result_code_reg       <= OC_NONE;
            init_pending_reg      <= 1'b0;
            motion_reg            <= 1'b0;
            first_label_valid_reg <= 1'b0;
            label_changed_reg     <= 1'b0;
            prev_pos_valid_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg             <= phase_next;
            result_code_reg       <= result_code_next;
            init_pending_reg      <= init_pending_next;
            motion_reg            <= motion_next;
            first_label_valid_reg <= first_label_valid_next;
            label_changed_reg     <= label_changed_next;
            prev_pos_valid_reg    <= prev_pos_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            goal_reg          <= goal_next;
            init_deadline_reg <= init_deadline_next;
            move_deadline_reg <= move_deadline_next;
            last_motion_reg   <= last_motion_next;
            start_pos_reg     <= start_pos_next;
            latest_pos_reg    <= latest_pos_next;
            first_label_reg   <= first_label_next;
            prev_pos_reg      <= prev_pos_next;
            res_accepted_reg  <= res_accepted_next;
            res_access_reg    <= res_access_next;
            res_target_reg    <= res_target_next;
        end
    end

    assign res_accepted      = res_accepted_reg;
    assign res_seq_state     = phase_reg;
    assign res_outcome       = result_code_reg;
    assign res_device_access = res_access_reg;
    assign res_target_out    = res_target_reg;

    a_outcome_iff_terminal: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_OK) || (phase_reg == PH_FAIL)) == (result_code_reg != OC_NONE))
        else $error("outcome does not match terminal phase");

    a_refused_start_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item_command == CMD_START && !idle_like)
        |=> ($stable(phase_reg) && $stable(goal_reg)))
        else $error("refused start changed the sequence");

endmodule

FILE: design/gripper_motion_sequencer_core.sv
// Top level of the gripper motion sequencer: request/result handshake and registers.
//
// Input channel (s_*): one request per valid/ready handshake. command selects a
// start (latches target_position) or a tick (carries time and the device answer
// to the access made in the current phase). A start during a running move is
// refused but still produces a result with accepted low.
// Result channel (m_*): exactly one result per request, in order, giving
// accepted, the phase after the request, the outcome, the device access used
// and the target driven with a write access.
// A taken request lands in the input register; the step logic loads the result
// register from it once the result channel can take a new result.
// Throughput: one request per cycle while m_ready is high; the state update is a
// single pass of compares and 32-bit adds between input and result registers.
// Stall: when m_ready is low the result register holds, the next request waits
// in the input register, and s_ready drops once both are full.
// Configuration (cfg_*): write-only, one register per cycle, no wait states; the user
// must write it only while no request is in flight; the block does not enforce it.
// Reset (aresetn low, synchronous): phase idle, outcome none, registers back to
// their defaults, both pipeline stages empty.
module gripper_motion_sequencer_core import gms_pkg::*; #(
    parameter int TIME_BITS     = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_BITS-1:0]        cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic [TIME_BITS-1:0]       s_now_ms,
    input  logic [POSITION_BITS-1:0]   s_target_position,
    input  logic                       s_read_ok,
    input  logic                       s_init_done,
    input  logic [1:0]                 s_clamp_label,
    input  logic [POSITION_BITS-1:0]   s_read_position,
    input  logic                       s_init_command_ok,
    input  logic [1:0]                 s_write_result,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [2:0]                 m_seq_state,
    output logic [3:0]                 m_outcome,
    output logic [1:0]                 m_device_access,
    output logic [TARGET_OUT_BITS-1:0] m_target_out
);

    cfg_t cfg;

    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_fire;
    logic step_en;

    logic                     in_command_reg;
    logic [TIME_BITS-1:0]     in_now_ms_reg;
    logic [POSITION_BITS-1:0] in_target_position_reg;
    logic                     in_read_ok_reg;
    logic                     in_init_done_reg;
    logic [1:0]               in_clamp_label_reg;
    logic [POSITION_BITS-1:0] in_read_position_reg;
    logic                     in_init_command_ok_reg;
    logic [1:0]               in_write_result_reg;

    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_command_reg         <= s_command;
            in_now_ms_reg          <= s_now_ms;
            in_target_position_reg <= s_target_position;
            in_read_ok_reg         <= s_read_ok;
            in_init_done_reg       <= s_init_done;
            in_clamp_label_reg     <= s_clamp_label;
            in_read_position_reg   <= s_read_position;
            in_init_command_ok_reg <= s_init_command_ok;
            in_write_result_reg    <= s_write_result;
        end
    end

    gms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gms_engine #(
        .TIME_BITS     (TIME_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step_en              (step_en),
        .cfg                  (cfg),
        .item_command         (in_command_reg),
        .item_now_ms          (in_now_ms_reg),
        .item_target_position (in_target_position_reg),
        .item_read_ok         (in_read_ok_reg),
        .item_init_done       (in_init_done_reg),
        .item_clamp_label     (in_clamp_label_reg),
        .item_read_position   (in_read_position_reg),
        .item_init_command_ok (in_init_command_ok_reg),
        .item_write_result    (in_write_result_reg),
        .res_accepted         (m_accepted),
        .res_seq_state        (m_seq_state),
        .res_outcome          (m_outcome),
        .res_device_access    (m_device_access),
        .res_target_out       (m_target_out)
    );

    assign m_valid = out_valid_reg;

    a_access_only_when_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_device_access != ACC_NONE) |-> m_accepted)
        else $error("device access reported for a refused request");

    a_target_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_device_access != ACC_WRITE) |-> (m_target_out == '0))
        else $error("target driven without a write access");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_valid)
        else $error("processed request produced no result");

endmodule
